// ===== rtl/uart8n1_pkg.sv =====
package uart8n1_pkg;

  localparam int BYTE_W = 8;
  localparam int PERIOD_W = 16;
  localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET = 16'd104;

  typedef struct packed {
    logic             tx_line;
    logic             tx_busy;
    logic [BYTE_W-1:0] rx_byte;
    logic             rx_valid;
  } result_t;

endpackage

// ===== rtl/uart_8n1_transceiver_top.sv =====
// UART transceiver, no parity, one stop bit, LSB first.
// Each input transaction is one line-sampling tick: rx_line, plus send_request
// and send_byte. Every accepted transaction yields exactly one output
// transaction with tx_line, tx_busy, rx_byte (last received byte) and
// rx_valid (high on the tick a byte completes).
// bit_period is written through the cfg channel (cfg_ready is always high);
// the user must write it only while the block is idle, which the block does not
// enforce; 0 acts as 1. Reset value is 104. The result of a tick is registered
// into the output register when that is free, else into the skid register.
// One tick is accepted per cycle while in_stall is low.
// When a valid output is stalled, a result is parked in a one-entry skid register;
// in_stall rises only once that entry is full, and clears the cycle after
// the output is taken.
// Reset (rst, synchronous): transmitter and receiver idle, held rx_byte 0,
// bit_period 104, output and skid empty.
module uart_8n1_transceiver_top
  import uart8n1_pkg::*;
#(
  parameter int DATA_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [PERIOD_W-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                rx_line,
  input  logic                send_request,
  input  logic [BYTE_W-1:0]   send_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                tx_line,
  output logic                tx_busy,
  output logic [BYTE_W-1:0]   rx_byte,
  output logic                rx_valid
);

  localparam int CNT_W = $clog2(DATA_BITS + 1);
  localparam int IDX_W = $clog2(BYTE_W);
  localparam logic [CNT_W-1:0] DATA_CNT = CNT_W'(DATA_BITS);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_DATA  = 2'd2,
    PH_STOP  = 2'd3
  } phase_t;

  logic [PERIOD_W-1:0] bit_period;
  phase_t              tx_phase, tx_phase_next;
  logic [BYTE_W-1:0]   tx_shift, tx_shift_next;
  logic [CNT_W-1:0]    tx_bits_left, tx_bits_left_next;
  logic [PERIOD_W-1:0] tx_timer, tx_timer_next;
  phase_t              rx_phase, rx_phase_next;
  logic [BYTE_W-1:0]   rx_shift, rx_shift_next;
  logic [CNT_W-1:0]    rx_bits_seen, rx_bits_seen_next;
  logic [PERIOD_W-1:0] rx_timer, rx_timer_next;
  logic [BYTE_W-1:0]   rx_hold, rx_hold_next;
  logic                rx_done;

  result_t result, out_reg, skid;
  logic    skid_valid;
  logic    accept;
  logic    out_free;
  logic [PERIOD_W-1:0] period_less_one;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !skid_valid;
  assign out_free  = !out_valid || !out_stall;

  assign period_less_one = (bit_period == '0) ? '0 : bit_period - 1'b1;

  always_comb begin
    tx_phase_next     = tx_phase;
    tx_shift_next     = tx_shift;
    tx_bits_left_next = tx_bits_left;
    tx_timer_next     = tx_timer;
    if (tx_phase == PH_IDLE) begin
      if (send_request) begin
        tx_shift_next = send_byte;
        tx_phase_next = PH_START;
        tx_timer_next = period_less_one;
      end
    end else if (tx_timer != '0) begin
      tx_timer_next = tx_timer - 1'b1;
    end else begin
      tx_timer_next = period_less_one;
      case (tx_phase)
        PH_START: begin
          tx_phase_next     = PH_DATA;
          tx_bits_left_next = DATA_CNT;
        end
        PH_DATA: begin
          tx_bits_left_next = tx_bits_left - 1'b1;
          if (tx_bits_left_next == '0) begin
            tx_phase_next = PH_STOP;
          end else begin
            tx_shift_next = tx_shift >> 1;
          end
        end
        default: begin
          tx_phase_next = PH_IDLE;
          tx_timer_next = '0;
        end
      endcase
    end
  end

  always_comb begin
    rx_phase_next     = rx_phase;
    rx_shift_next     = rx_shift;
    rx_bits_seen_next = rx_bits_seen;
    rx_timer_next     = rx_timer;
    rx_hold_next      = rx_hold;
    rx_done           = 1'b0;
    if (rx_phase == PH_IDLE) begin
      if (!rx_line) begin
        rx_phase_next = PH_START;
        rx_timer_next = period_less_one >> 1;
      end
    end else if (rx_timer != '0) begin
      rx_timer_next = rx_timer - 1'b1;
    end else begin
      rx_timer_next = period_less_one;
      case (rx_phase)
        PH_START: begin
          rx_phase_next     = PH_DATA;
          rx_shift_next     = '0;
          rx_bits_seen_next = '0;
        end
        PH_DATA: begin
          // a ninth data bit falls outside the byte and is dropped
          if (rx_line && (int'(rx_bits_seen) < BYTE_W)) begin
            rx_shift_next[rx_bits_seen[IDX_W-1:0]] = 1'b1;
          end
          rx_bits_seen_next = rx_bits_seen + 1'b1;
          if (rx_bits_seen_next >= DATA_CNT) begin
            rx_hold_next  = rx_shift_next;
            rx_phase_next = PH_STOP;
            rx_done       = 1'b1;
          end
        end
        default: begin
          rx_phase_next = PH_IDLE;
          rx_timer_next = '0;
        end
      endcase
    end
  end

  always_comb begin
    case (tx_phase_next)
      PH_START: result.tx_line = 1'b0;
      PH_DATA:  result.tx_line = tx_shift_next[0];
      default:  result.tx_line = 1'b1;
    endcase
    result.tx_busy  = (tx_phase_next != PH_IDLE);
    result.rx_byte  = rx_hold_next;
    result.rx_valid = rx_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period   <= BIT_PERIOD_RESET;
      tx_phase     <= PH_IDLE;
      tx_shift     <= '0;
      tx_bits_left <= '0;
      tx_timer     <= '0;
      rx_phase     <= PH_IDLE;
      rx_shift     <= '0;
      rx_bits_seen <= '0;
      rx_timer     <= '0;
      rx_hold      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        bit_period <= cfg_data;
      end
      if (accept) begin
        tx_phase     <= tx_phase_next;
        tx_shift     <= tx_shift_next;
        tx_bits_left <= tx_bits_left_next;
        tx_timer     <= tx_timer_next;
        rx_phase     <= rx_phase_next;
        rx_shift     <= rx_shift_next;
        rx_bits_seen <= rx_bits_seen_next;
        rx_timer     <= rx_timer_next;
        rx_hold      <= rx_hold_next;
      end
    end
  end

  // output register with one-entry skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_reg <= skid;
      end else if (accept) begin
        out_reg <= result;
      end
    end else if (accept) begin
      skid <= result;
    end
  end

  assign tx_line  = out_reg.tx_line;
  assign tx_busy  = out_reg.tx_busy;
  assign rx_byte  = out_reg.rx_byte;
  assign rx_valid = out_reg.rx_valid;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output transaction");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_valid && out_stall) |=> skid_valid)
    else $error("skid entry lost while output stalled");

  a_idle_line_high: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !tx_busy) |-> tx_line)
    else $error("tx line low while transmitter idle");

  a_data_bits_left: assert property (@(posedge clk) disable iff (rst)
    (tx_phase == PH_DATA) |-> (tx_bits_left != '0))
    else $error("data phase with no bits left");

  a_rx_count_bound: assert property (@(posedge clk) disable iff (rst)
    (rx_phase == PH_DATA) |-> (rx_bits_seen < DATA_CNT))
    else $error("receiver bit count past frame length");

endmodule

// ===== dv/uart_8n1_transceiver_checker.sv =====
`timescale 1ns / 100ps

module uart_8n1_transceiver_checker
  import uart8n1_pkg::*;
#(
  parameter int DATA_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [PERIOD_W-1:0] cfg_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                rx_line,
  input  logic                send_request,
  input  logic [BYTE_W-1:0]   send_byte,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic                tx_line,
  input  logic                tx_busy,
  input  logic [BYTE_W-1:0]   rx_byte,
  input  logic                rx_valid,
  output int                  mismatches,
  output int                  pending
);

  typedef enum logic [1:0] {ST_IDLE, ST_START, ST_DATA, ST_STOP} frame_phase_t;

  logic [PERIOD_W-1:0] bit_ticks;
  frame_phase_t        tx_ph;
  frame_phase_t        rx_ph;
  logic [15:0]         tx_sr;
  logic [15:0]         rx_sr;
  logic [3:0]          tx_left;
  logic [3:0]          rx_seen;
  logic [PERIOD_W-1:0] tx_cnt;
  logic [PERIOD_W-1:0] rx_cnt;
  logic [BYTE_W-1:0]   rx_last;
  result_t             tick_results_q[$];
  int                  out_count;

  initial begin
    mismatches = 0;
    pending = 0;
    out_count = 0;
  end

  function automatic logic [PERIOD_W-1:0] ticks_less_one();
    return (bit_ticks == '0) ? '0 : bit_ticks - 1'b1;
  endfunction

  task automatic clear_uart_state();
    bit_ticks = BIT_PERIOD_RESET;
    tx_ph = ST_IDLE;
    rx_ph = ST_IDLE;
    tx_sr = '0;
    rx_sr = '0;
    tx_left = '0;
    rx_seen = '0;
    tx_cnt = '0;
    rx_cnt = '0;
    rx_last = '0;
  endtask

  task automatic advance_uart_tick(input logic line, input logic req,
                                   input logic [BYTE_W-1:0] data, output result_t r);
    logic done;
    done = 1'b0;

    if (tx_ph == ST_IDLE) begin
      if (req) begin
        tx_sr = {8'h00, data};
        tx_ph = ST_START;
        tx_cnt = ticks_less_one();
      end
    end else if (tx_cnt != '0) begin
      tx_cnt = tx_cnt - 1'b1;
    end else begin
      tx_cnt = ticks_less_one();
      case (tx_ph)
        ST_START: begin
          tx_ph = ST_DATA;
          tx_left = 4'(DATA_BITS);
        end
        ST_DATA: begin
          tx_left = tx_left - 1'b1;
          if (tx_left == '0) tx_ph = ST_STOP;
          else tx_sr = tx_sr >> 1;
        end
        default: begin
          tx_ph = ST_IDLE;
          tx_cnt = '0;
        end
      endcase
    end

    if (rx_ph == ST_IDLE) begin
      if (!line) begin
        rx_ph = ST_START;
        rx_cnt = ticks_less_one() >> 1;
      end
    end else if (rx_cnt != '0) begin
      rx_cnt = rx_cnt - 1'b1;
    end else begin
      rx_cnt = ticks_less_one();
      case (rx_ph)
        ST_START: begin
          rx_ph = ST_DATA;
          rx_sr = '0;
          rx_seen = '0;
        end
        ST_DATA: begin
          if (line) rx_sr[rx_seen] = 1'b1;
          rx_seen = rx_seen + 1'b1;
          if (rx_seen >= DATA_BITS) begin
            rx_last = rx_sr[BYTE_W-1:0];
            rx_ph = ST_STOP;
            done = 1'b1;
          end
        end
        default: begin
          rx_ph = ST_IDLE;
          rx_cnt = '0;
        end
      endcase
    end

    r.tx_line = (tx_ph == ST_START) ? 1'b0 : (tx_ph == ST_DATA) ? tx_sr[0] : 1'b1;
    r.tx_busy = (tx_ph != ST_IDLE);
    r.rx_byte = rx_last;
    r.rx_valid = done;
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: output transaction %0d: %s", $realtime, out_count, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [BYTE_W-1:0] got_v,
                               input logic [BYTE_W-1:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got_v, want_v));
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst) begin
      clear_uart_state();
      tick_results_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) bit_ticks = cfg_data;

      if (out_valid && !out_stall) begin
        got.tx_line = tx_line;
        got.tx_busy = tx_busy;
        got.rx_byte = rx_byte;
        got.rx_valid = rx_valid;
        if (tick_results_q.size() == 0) begin
          report_mismatch("no transaction outstanding");
        end else begin
          want = tick_results_q.pop_front();
          compare_field("tx_line", BYTE_W'(got.tx_line), BYTE_W'(want.tx_line));
          compare_field("tx_busy", BYTE_W'(got.tx_busy), BYTE_W'(want.tx_busy));
          compare_field("rx_byte", got.rx_byte, want.rx_byte);
          compare_field("rx_valid", BYTE_W'(got.rx_valid), BYTE_W'(want.rx_valid));
        end
        out_count++;
      end

      if (in_valid && !in_stall) begin
        advance_uart_tick(rx_line, send_request, send_byte, want);
        tick_results_q.push_back(want);
      end
    end
    pending = tick_results_q.size();
  end

endmodule

// ===== dv/uart_8n1_transceiver_top_tb.sv =====
`timescale 1ns / 100ps

module uart_8n1_transceiver_top_tb;
  import uart8n1_pkg::*;

  localparam int DATA_BITS = 8;
  localparam int LIMIT_CYCLES = 300000;
  localparam int HOLD_CYCLES = 200;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [PERIOD_W-1:0] cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic                rx_line;
  logic                send_request;
  logic [BYTE_W-1:0]   send_byte;
  logic                out_valid;
  logic                out_stall;
  logic                tx_line;
  logic                tx_busy;
  logic [BYTE_W-1:0]   rx_byte;
  logic                rx_valid;

  int mismatches;
  int pending;
  int cycles = 0;
  int burst_left = 0;
  int hold_req = 0;

  always #5 clk = ~clk;

  uart_8n1_transceiver_top #(.DATA_BITS(DATA_BITS)) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .rx_line(rx_line), .send_request(send_request), .send_byte(send_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .tx_line(tx_line), .tx_busy(tx_busy), .rx_byte(rx_byte), .rx_valid(rx_valid)
  );

  uart_8n1_transceiver_checker #(.DATA_BITS(DATA_BITS)) checker_i (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .rx_line(rx_line), .send_request(send_request), .send_byte(send_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .tx_line(tx_line), .tx_busy(tx_busy), .rx_byte(rx_byte), .rx_valid(rx_valid),
    .mismatches(mismatches), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : receiver_side
    int          hold_left;
    int          hold_seen;
    int          stretch;
    stall_mode_t mode;
    hold_left = 0;
    hold_seen = 0;
    stretch = 0;
    mode = STALL_NONE;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (stretch == 0) begin
        stretch = $urandom_range(5, 60);
        mode = stall_mode_t'($urandom_range(0, 3));
      end
      stretch--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= (cycles % 3 == 0);
        endcase
      end
    end
  end

  function automatic logic rand_req();
    return ($urandom_range(0, 7) == 0);
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic rand_bit();
    return ($urandom_range(0, 1) != 0);
  endfunction

  // one line tick; returns at the edge where the transaction is taken
  task automatic tick(input logic line, input logic req, input logic [BYTE_W-1:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    rx_line <= line;
    send_request <= req;
    send_byte <= data;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_period(input logic [PERIOD_W-1:0] value);
    drain_results();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // start bit, data LSB first, stop bit; cut shortens the frame
  task automatic send_frame(input logic [BYTE_W-1:0] data, input int ticks_per_bit,
                            input logic stop_level, input int cut);
    logic [9:0] bits;
    bits = {stop_level, data, 1'b0};
    for (int i = 0; i < 10 && i < cut; i++)
      repeat (ticks_per_bit) tick(bits[i], rand_req(), rand_byte());
  endtask

  task automatic run_phase(input logic [PERIOD_W-1:0] per, input int n_items,
                           input bit with_hold);
    int eff;
    int stop_at;
    int pick;
    int items_done;
    eff = (per == '0) ? 1 : int'(per);
    set_period(per);
    if (with_hold) hold_req++;
    items_done = 0;
    while (items_done < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        send_frame(rand_byte(), eff, ($urandom_range(0, 7) != 0), 10);
        items_done += 10 * eff;
      end else if (pick < 8) begin
        stop_at = $urandom_range(1, 2 * eff + 2);
        repeat (stop_at) tick(rand_bit(), rand_req(), rand_byte());
        items_done += stop_at;
      end else begin
        stop_at = $urandom_range(1, 9);
        send_frame(rand_byte(), eff, rand_bit(), stop_at);
        items_done += stop_at * eff;
      end
      stop_at = $urandom_range(0, 2 * eff);
      repeat (stop_at) tick(1'b1, rand_req(), rand_byte());
      items_done += stop_at;
    end
  endtask

  initial begin : stimulus
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    rx_line <= 1'b1;
    send_request <= 1'b0;
    send_byte <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    tick(1'b1, 1'b1, 8'hFF);
    tick(1'b1, 1'b1, 8'h00);
    tick(1'b0, 1'b0, 8'h00);
    set_period(16'd0);
    send_frame(8'h00, 1, 1'b0, 10);
    send_frame(8'hFF, 1, 1'b1, 10);

    run_phase(16'd1, 50, 1'b0);
    run_phase(16'd2, 55, 1'b0);
    run_phase(16'd3, 60, 1'b0);
    run_phase(16'd5, 50, 1'b0);
    run_phase(16'd4, 50, 1'b1);
    run_phase(16'd2, 45, 1'b0);
    run_phase(16'd7, 40, 1'b0);
    // let both directions finish their frames before the slowest rate
    repeat (11 * 7) tick(1'b1, 1'b0, rand_byte());

    set_period(16'hFFFF);
    tick(1'b1, 1'b1, 8'h5A);
    repeat (3) tick(1'b0, 1'b0, rand_byte());
    repeat (16) tick(rand_bit(), rand_req(), rand_byte());

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
